// ===== rtl/core/itoa_pkg.sv =====
// Shared types and constants for the integer to ASCII digits block.
package itoa_pkg;

  // Format kind codes carried on the input tuser field
  localparam logic [2:0] KIND_UDEC = 3'd0;
  localparam logic [2:0] KIND_SDEC = 3'd1;
  localparam logic [2:0] KIND_HEXL = 3'd2;
  localparam logic [2:0] KIND_HEXU = 3'd3;
  localparam logic [2:0] KIND_PTR  = 3'd4;

  localparam int unsigned KindW   = 3;
  localparam int unsigned ValueW  = 64;
  localparam int unsigned CharW   = 8;
  localparam int unsigned CountW  = 5;
  localparam int unsigned OutW    = 16;
  localparam int unsigned NibW    = 4;
  localparam int unsigned NibCnt  = 16;
  localparam int unsigned BcdDig  = 10;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;   // capture a new item
    logic conv;   // one double-dabble step, two bits
    logic find;   // locate the top significant digit
    logic emit;   // produce one character into the output register
  } itoa_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic conv_last;   // this conversion step is the final one
    logic final_char;  // next character to emit is the last one
  } itoa_sts_t;

endpackage

// ===== rtl/core/itoa_dp.sv =====
// Datapath: magnitude capture, binary to BCD conversion, digit pointer and output register.
module itoa_dp #(
  parameter int unsigned POINTER_BITS = 64
) (
  input  logic                        clk,
  input  itoa_pkg::itoa_cmd_t         cmd,
  output itoa_pkg::itoa_sts_t         sts,
  input  logic [itoa_pkg::KindW-1:0]  kind,
  input  logic [itoa_pkg::ValueW-1:0] value,
  output logic [itoa_pkg::CharW-1:0]  character,
  output logic [itoa_pkg::CountW-1:0] char_count,
  output logic                        last
);

  localparam logic [itoa_pkg::ValueW-1:0] PtrMask =
    {itoa_pkg::ValueW{1'b1}} >> (itoa_pkg::ValueW - POINTER_BITS);
  localparam int unsigned BcdW = itoa_pkg::BcdDig * itoa_pkg::NibW;

  logic [itoa_pkg::ValueW-1:0] dig;        // hex nibbles or BCD digits
  logic [31:0]                 bin;        // magnitude being shifted into BCD
  logic                        minus;      // minus sign still pending
  logic                        upper;      // upper-case letters
  logic [3:0]                  iter;       // conversion step counter
  logic [3:0]                  idx;        // digit to emit next
  logic [itoa_pkg::CountW-1:0] cnt;        // characters emitted so far

  logic [31:0]                 low32;
  logic [31:0]                 mag32;
  logic                        is_dec;
  logic                        is_neg;
  logic [BcdW-1:0]             bcd_next;
  logic [3:0]                  top;
  logic [3:0]                  nib;
  logic [itoa_pkg::CharW-1:0]  char_next;

  // Add three to every BCD digit of five or more, then shift in one bit
  function automatic logic [BcdW-1:0] dabble(input logic [BcdW-1:0] b, input logic bit_in);
    logic [BcdW-1:0] a;
    a = b;
    for (int d = 0; d < itoa_pkg::BcdDig; d++) begin
      if (a[d*4 +: 4] >= 4'd5) begin
        a[d*4 +: 4] = a[d*4 +: 4] + 4'd3;
      end
    end
    return {a[BcdW-2:0], bit_in};
  endfunction

  // Map one digit to its ASCII code
  function automatic logic [itoa_pkg::CharW-1:0] digit_char(input logic [3:0] n,
                                                             input logic up);
    if (n < 4'd10) begin
      return 8'h30 + {4'd0, n};
    end else if (up) begin
      return 8'h37 + {4'd0, n};
    end else begin
      return 8'h57 + {4'd0, n};
    end
  endfunction

  // Decode the incoming item
  always_comb begin
    low32  = value[31:0];
    is_dec = (kind == itoa_pkg::KIND_UDEC) || (kind == itoa_pkg::KIND_SDEC);
    is_neg = (kind == itoa_pkg::KIND_SDEC) && low32[31];
    mag32  = is_neg ? (~low32 + 32'd1) : low32;
  end

  // Two conversion steps per cycle
  assign bcd_next = dabble(dabble(dig[BcdW-1:0], bin[31]), bin[30]);

  // Locate the highest nonzero digit; zero keeps digit zero
  always_comb begin
    top = '0;
    for (int i = 0; i < itoa_pkg::NibCnt; i++) begin
      if (|dig[i*4 +: 4]) begin
        top = 4'(i);
      end
    end
  end

  // Select the next character
  always_comb begin
    nib = dig[{idx, 2'b00} +: 4];
    char_next = minus ? 8'h2D : digit_char(nib, upper);
  end

  assign sts.conv_last  = (iter == 4'd15);
  assign sts.final_char = !minus && (idx == 4'd0);

  // Datapath registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      minus <= is_neg;
      upper <= (kind == itoa_pkg::KIND_HEXU);
      bin   <= mag32;
      iter  <= '0;
      if (kind == itoa_pkg::KIND_PTR) begin
        dig <= value & PtrMask;
      end else if (is_dec) begin
        dig <= '0;
      end else begin
        dig <= {32'd0, low32};
      end
    end
    if (cmd.conv) begin
      dig[BcdW-1:0] <= bcd_next;
      bin           <= {bin[29:0], 2'b00};
      iter          <= iter + 4'd1;
    end
    if (cmd.find) begin
      idx <= top;
      cnt <= '0;
    end
    if (cmd.emit) begin
      character  <= char_next;
      char_count <= cnt + 5'd1;
      last       <= !minus && (idx == 4'd0);
      cnt        <= cnt + 5'd1;
      if (minus) begin
        minus <= 1'b0;
      end else begin
        idx <= idx - 4'd1;
      end
    end
  end

endmodule

// ===== rtl/core/itoa_ctrl.sv =====
// Controller: sequences capture, conversion, digit search and character transfers.
module itoa_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [itoa_pkg::KindW-1:0] kind,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output itoa_pkg::itoa_cmd_t        cmd,
  input  itoa_pkg::itoa_sts_t        sts
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_FIND,
    ST_EMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   kind_ok;
  logic   kind_dec;
  logic   out_free;

  always_comb begin
    kind_ok  = (kind == itoa_pkg::KIND_UDEC) || (kind == itoa_pkg::KIND_SDEC) ||
               (kind == itoa_pkg::KIND_HEXL) || (kind == itoa_pkg::KIND_HEXU) ||
               (kind == itoa_pkg::KIND_PTR);
    kind_dec = (kind == itoa_pkg::KIND_UDEC) || (kind == itoa_pkg::KIND_SDEC);
    out_free = !m_tvalid || m_tready;
  end

  assign s_tready = (state == ST_IDLE);

  // Decode commands and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid && kind_ok) begin
          cmd.load   = 1'b1;
          state_next = kind_dec ? ST_CONV : ST_FIND;
        end
      end
      ST_CONV: begin
        cmd.conv = 1'b1;
        if (sts.conv_last) begin
          state_next = ST_FIND;
        end
      end
      ST_FIND: begin
        cmd.find   = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.emit = 1'b1;
          if (sts.final_char) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Hold state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!m_tvalid || m_tready))
    else $error("character produced over an untaken one");
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (!cmd.conv && !cmd.emit && !cmd.find))
    else $error("datapath busy while input is open");
  a_final_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && sts.final_char) |=> s_tready)
    else $error("input not reopened after final character");
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> m_tvalid)
    else $error("emitted character not presented");
`endif

endmodule

// ===== rtl/core/integer_to_ascii_digits.sv =====
// Top level: integer to ASCII decimal and hex digit stream.
//
//  channel  dir  tdata                                   tuser      tlast
//  s_*      in   [63:0] value                            [2:0] kind  -
//  m_*      out  [7:0] character, [12:8] char_count      -           last
//
// An input transfer is taken only when the block is idle; the next one is
// taken the cycle after the final character enters the output register.
// Hex kinds go from capture through the digit search to one transfer per character;
// decimal kinds add the two-bit-per-cycle BCD conversion before the search.
// Output stalls hold the character sequencer. Kinds 5 to 7 are dropped.
// Reset clears the controller and the output valid only.
module integer_to_ascii_digits #(
  parameter int unsigned POINTER_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [63:0] value
  input  logic [2:0]  s_tuser,   // [2:0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] character, [12:8] char_count, [15:13] zero
  output logic        m_tlast
);

  itoa_pkg::itoa_cmd_t         cmd;
  itoa_pkg::itoa_sts_t         sts;
  logic [itoa_pkg::CharW-1:0]  character;
  logic [itoa_pkg::CountW-1:0] char_count;

  itoa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .kind     (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  itoa_dp #(
    .POINTER_BITS (POINTER_BITS)
  ) u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .sts        (sts),
    .kind       (s_tuser),
    .value      (s_tdata),
    .character  (character),
    .char_count (char_count),
    .last       (m_tlast)
  );

  assign m_tdata = {3'b000, char_count, character};

endmodule

// ===== dv/tb_integer_to_ascii_digits.sv =====
// Testbench for integer_to_ascii_digits: directed and random stream stimulus with per-character checking.
`timescale 1ns / 100ps

module tb_integer_to_ascii_digits;

  localparam int unsigned PTR_BITS = 64;
  localparam logic [63:0] PTR_MASK =
    (PTR_BITS >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << PTR_BITS) - 64'd1);
  localparam int RANDOM_NUMBERS = 185;
  localparam int HOLD_AT_CHAR   = 30;    // character count at which the sink holds off
  localparam int HOLD_CYCLES    = 400;
  localparam int TAIL_CYCLES    = 60;
  localparam int IDLE_LIMIT     = 3000;
  localparam logic [2:0] KIND_UNUSED_LO  = 3'd5;
  localparam logic [2:0] KIND_UNUSED_MID = 3'd6;
  localparam logic [2:0] KIND_UNUSED_HI  = 3'd7;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] value;
  } number_t;

  typedef struct packed {
    logic [7:0] ch;
    logic [4:0] count;
    logic       last;
  } glyph_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tlast;

  number_t pending_numbers[$];
  glyph_t  expected_glyphs[$];

  int gap_left = 0;
  int stall_left = 0;
  bit hold_done = 1'b0;
  int n_sent = 0;
  int n_dropped = 0;
  int n_chars = 0;
  int n_errors = 0;
  int idle_cycles = 0;

  integer_to_ascii_digits #(
    .POINTER_BITS(PTR_BITS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Queue the characters one number should produce, most significant first
  function automatic void predict_digits(input logic [2:0] kind, input logic [63:0] value);
    logic [63:0] mag;
    logic [63:0] radix;
    logic [3:0]  d;
    logic [7:0]  rev [16];
    logic [7:0]  seq [$];
    bit          upper;
    int          nd;
    glyph_t      g;
    mag = {32'd0, value[31:0]};
    radix = 64'd10;
    upper = 1'b0;
    nd = 0;
    case (kind)
      itoa_pkg::KIND_UDEC: ;
      itoa_pkg::KIND_SDEC: begin
        // negative: sign first, magnitude in 32 unsigned bits (most negative wraps to itself)
        if (value[31]) begin
          seq.push_back("-");
          mag = {32'd0, (~value[31:0]) + 32'd1};
        end
      end
      itoa_pkg::KIND_HEXL: radix = 64'd16;
      itoa_pkg::KIND_HEXU: begin
        radix = 64'd16;
        upper = 1'b1;
      end
      itoa_pkg::KIND_PTR: begin
        radix = 64'd16;
        mag = value & PTR_MASK;
      end
      default: return;
    endcase
    do begin
      d = 4'(mag % radix);
      rev[nd] = (d < 10) ? 8'("0" + d) : 8'((upper ? "A" : "a") + d - 10);
      mag = mag / radix;
      nd++;
    end while (mag != 0 && nd < 16);
    for (int i = nd - 1; i >= 0 && seq.size() < 16; i--) seq.push_back(rev[i]);
    foreach (seq[i]) begin
      g.ch = seq[i];
      g.count = 5'(i + 1);
      g.last = (i == seq.size() - 1);
      expected_glyphs.push_back(g);
    end
  endfunction

  // Random value with a random significant width and, except for pointers, optional junk above bit 31
  function automatic logic [63:0] shaped_value(input logic [2:0] kind);
    logic [63:0] v;
    int w;
    v = {$urandom, $urandom};
    w = $urandom_range(0, 64);
    if (w < 64) v = v & ((64'd1 << w) - 64'd1);
    if (kind != itoa_pkg::KIND_PTR && $urandom_range(0, 1)) v[63:32] = $urandom;
    if (kind == itoa_pkg::KIND_SDEC && $urandom_range(0, 1)) v[31:0] = ~v[31:0];
    return v;
  endfunction

  function automatic int next_gap();
    if ((n_sent / 30) % 4 == 2) return 0;
    return $urandom_range(0, 10);
  endfunction

  task automatic note_mismatch(input string msg);
    n_errors++;
    if (n_errors <= 10) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // Reset, stimulus, end of run
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    number_t nb;
    int numbered;
    // directed: extremes, every kind, sign cases, ignored upper bits, unused kinds
    pending_numbers.push_back('{itoa_pkg::KIND_UDEC, 64'd0});
    pending_numbers.push_back('{itoa_pkg::KIND_UDEC, 64'd9});
    pending_numbers.push_back('{itoa_pkg::KIND_UDEC, 64'd10});
    pending_numbers.push_back('{itoa_pkg::KIND_UDEC, 64'h0000_0000_FFFF_FFFF});
    pending_numbers.push_back('{itoa_pkg::KIND_UDEC, 64'hFFFF_FFFF_FFFF_FFFF});
    pending_numbers.push_back('{itoa_pkg::KIND_UDEC, 64'h1234_5678_0000_007B});
    pending_numbers.push_back('{itoa_pkg::KIND_SDEC, 64'd0});
    pending_numbers.push_back('{itoa_pkg::KIND_SDEC, 64'h0000_0000_7FFF_FFFF});
    pending_numbers.push_back('{itoa_pkg::KIND_SDEC, 64'h0000_0000_8000_0000});
    pending_numbers.push_back('{itoa_pkg::KIND_SDEC, 64'h0000_0000_FFFF_FFFF});
    pending_numbers.push_back('{itoa_pkg::KIND_SDEC, 64'h0000_0000_FFFF_FFF6});
    pending_numbers.push_back('{itoa_pkg::KIND_SDEC, 64'hABCD_0000_8000_0001});
    pending_numbers.push_back('{itoa_pkg::KIND_HEXL, 64'd0});
    pending_numbers.push_back('{itoa_pkg::KIND_HEXL, 64'h0000_0000_DEAD_BEEF});
    pending_numbers.push_back('{itoa_pkg::KIND_HEXL, 64'hFFFF_FFFF_0000_000F});
    pending_numbers.push_back('{itoa_pkg::KIND_HEXU, 64'h0000_0000_DEAD_BEEF});
    pending_numbers.push_back('{itoa_pkg::KIND_HEXU, 64'hFFFF_FFFF_FFFF_FFFF});
    pending_numbers.push_back('{itoa_pkg::KIND_PTR, 64'd0});
    pending_numbers.push_back('{itoa_pkg::KIND_PTR, 64'hFFFF_FFFF_FFFF_FFFF});
    pending_numbers.push_back('{itoa_pkg::KIND_PTR, 64'h0123_4567_89AB_CDEF});
    pending_numbers.push_back('{itoa_pkg::KIND_PTR, 64'h0000_0001_0000_0000});
    pending_numbers.push_back('{KIND_UNUSED_LO, {$urandom, $urandom}});
    pending_numbers.push_back('{KIND_UNUSED_MID, {$urandom, $urandom}});
    pending_numbers.push_back('{KIND_UNUSED_HI, {$urandom, $urandom}});
    pending_numbers.push_back('{itoa_pkg::KIND_SDEC, 64'hFFFF_FFFF_8000_0000});

    // random: mostly valid kinds, an occasional unused one
    numbered = 0;
    while (numbered < RANDOM_NUMBERS) begin
      if ($urandom_range(0, 19) == 0) begin
        nb.kind = 3'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
        nb.value = {$urandom, $urandom};
      end else begin
        nb.kind = 3'($urandom_range(itoa_pkg::KIND_UDEC, itoa_pkg::KIND_PTR));
        nb.value = shaped_value(nb.kind);
        numbered++;
      end
      pending_numbers.push_back(nb);
    end

    @(negedge rst);
    while (pending_numbers.size() != 0 || s_tvalid || expected_glyphs.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("summary: %0d numbers accepted (%0d with unused kinds), %0d characters checked",
             n_sent, n_dropped, n_chars);
    $display("summary: sink hold-off of %0d cycles applied, %0d mismatches", HOLD_CYCLES,
             n_errors);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Drive numbers from the pending queue with a random gap after each accepted one, none in some stretches
  always @(posedge clk) begin
    number_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_digits(s_tuser, s_tdata);
        n_sent++;
        if (s_tuser > itoa_pkg::KIND_PTR) n_dropped++;
        gap_left = next_gap();
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pending_numbers.size() != 0) begin
          nxt = pending_numbers.pop_front();
          s_tdata <= nxt.value;
          s_tuser <= nxt.kind;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Sink readiness: short random stalls, quiet stretches, one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        stall_left = ((n_chars / 50) % 4 == 3) ? 0 : $urandom_range(0, 10);
        if (n_chars >= HOLD_AT_CHAR && !hold_done) begin
          stall_left = HOLD_CYCLES;
          hold_done = 1'b1;
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Check each character transfer against the oldest expectation
  always @(posedge clk) begin
    glyph_t got;
    glyph_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.ch = m_tdata[7:0];
      got.count = m_tdata[12:8];
      got.last = m_tlast;
      n_chars++;
      if (expected_glyphs.size() == 0) begin
        note_mismatch($sformatf("unexpected character %02h count %0d last %0b",
                                got.ch, got.count, got.last));
      end else begin
        want = expected_glyphs.pop_front();
        if (got.ch !== want.ch || got.count !== want.count || got.last !== want.last)
          note_mismatch($sformatf("char %02h/%02h count %0d/%0d last %0b/%0b (exp/act)",
                                  want.ch, got.ch, want.count, got.count,
                                  want.last, got.last));
      end
    end
  end

  // Watchdog: end the run if no transfer happens for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d cycles without a transfer", IDLE_LIMIT);
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
